// ===== rtl/ntc_beta_temperature_converter_unit_defines.svh =====
// assertion macros for the ntc beta temperature converter
`ifndef NTC_BETA_TEMPERATURE_CONVERTER_UNIT_DEFINES_SVH
`define NTC_BETA_TEMPERATURE_CONVERTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NTC_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NTC_ASSERT_HOLDS(lbl, ante, cons, msg)
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ntc_pkg.sv =====
// shared types and constants of the ntc beta temperature converter
`default_nettype none
package ntc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 20;

    localparam logic [CfgIdxW-1:0] REG_SUPPLY  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FIXED   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_NOMINAL = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BETA    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MIN     = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MAX     = 3'd5;

    localparam int DivW           = 48;
    localparam int DivCellsRatio  = 48;
    localparam int DivCellsTerm   = 45;
    localparam int DivCellsKelvin = 48;
    localparam int NormCells      = 31;
    localparam int SqCells        = 30;

    // ln 2 in Q30
    localparam logic [29:0] Ln2Q30 = 30'd744261118;
    // 1/298.15 K in Q40, rounded
    localparam logic [31:0] InvT25Q40 =
        32'(((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815);
    localparam logic [47:0] CentiKNum = 48'(64'd100 << 40);
    localparam logic signed [48:0] ZeroCCentiK = 49'sd27315;

    typedef struct packed {
        logic        read_ok;
        logic [11:0] tap_millivolts;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] temp_centi_celsius;
        logic               temp_valid;
    } out_item_t;

    typedef struct packed {
        logic            vld;
        logic            bad;
        logic            neg;
        logic [DivW-1:0] num;
        logic [DivW-1:0] den;
        logic [DivW-1:0] rem;
        logic [DivW-1:0] quo;
    } div_t;

    typedef struct packed {
        logic        vld;
        logic        bad;
        logic [31:0] x;
        logic [4:0]  p;
    } norm_t;

    typedef struct packed {
        logic        vld;
        logic        bad;
        logic [30:0] m;
        logic [29:0] frac;
        logic [4:0]  p;
    } sq_t;

endpackage
`default_nettype wire

// ===== rtl/ntc_div_cell.sv =====
// one restoring division step: one quotient bit per cell
`default_nettype none
module ntc_div_cell (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          en,
    input  ntc_pkg::div_t d,
    output ntc_pkg::div_t q
);
    import ntc_pkg::*;

    logic [DivW:0] trial;
    logic [DivW:0] diff;
    logic          take;
    div_t          stage_next;
    div_t          stage_reg;
    logic          vld_reg;

    always_comb
    begin
        trial = {d.rem, d.num[DivW-1]};
        diff  = trial - {1'b0, d.den};
        take  = (trial >= {1'b0, d.den});
        stage_next     = d;
        stage_next.num = {d.num[DivW-2:0], 1'b0};
        stage_next.rem = take ? diff[DivW-1:0] : trial[DivW-1:0];
        stage_next.quo = {d.quo[DivW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= d.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        q     = stage_reg;
        q.vld = vld_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/ntc_norm_cell.sv =====
// one normalising step: shift left by one until the leading one reaches the top
`default_nettype none
module ntc_norm_cell (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           en,
    input  ntc_pkg::norm_t d,
    output ntc_pkg::norm_t q
);
    import ntc_pkg::*;

    norm_t stage_next;
    norm_t stage_reg;
    logic  vld_reg;

    always_comb
    begin
        stage_next = d;
        if (!d.x[31])
        begin
            stage_next.x = {d.x[30:0], 1'b0};
            stage_next.p = d.p - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= d.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        q     = stage_reg;
        q.vld = vld_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/ntc_sq_cell.sv =====
// one log2 fraction bit by squaring the q1.30 mantissa
`default_nettype none
module ntc_sq_cell (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         en,
    input  ntc_pkg::sq_t d,
    output ntc_pkg::sq_t q
);
    import ntc_pkg::*;

    logic [61:0] prod;
    logic [31:0] sq;
    sq_t         stage_next;
    sq_t         stage_reg;
    logic        vld_reg;

    always_comb
    begin
        prod       = d.m * d.m;
        sq         = prod[61:30];
        stage_next = d;
        if (sq[31])
        begin
            stage_next.m    = sq[31:1];
            stage_next.frac = {d.frac[28:0], 1'b1};
        end
        else
        begin
            stage_next.m    = sq[30:0];
            stage_next.frac = {d.frac[28:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= d.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        q     = stage_reg;
        q.vld = vld_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/ntc_beta_temperature_converter_unit.sv =====
// top level of the ntc beta temperature converter
// Converts a divider tap voltage into a temperature in hundredths of a degree
// with the thermistor beta equation. One reading is taken per clock unless the
// chain holds, and every reading gives exactly one result. The chained bit-per-cell
// units are a 48-cell resistance ratio divider, a 31-cell normaliser, 30 squaring
// cells for the log2 fraction, a 45-cell divide by beta and a 48-cell reciprocal
// divider, with glue registers around them. The whole chain holds while a finished
// result waits and the last reciprocal divider cell holds an item. Registers are
// to be written by the user through the cfg port while idle; nothing enforces it.
`default_nettype none
`include "ntc_beta_temperature_converter_unit_defines.svh"
module ntc_beta_temperature_converter_unit (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  ntc_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  wire                            out_ready,
    output ntc_pkg::out_item_t             out_item,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [ntc_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire [ntc_pkg::CfgDataW-1:0]    cfg_data
);
    import ntc_pkg::*;

    logic [11:0]        supply_reg;
    logic [19:0]        fixed_reg;
    logic [19:0]        nominal_reg;
    logic [13:0]        beta_reg;
    logic signed [15:0] min_reg;
    logic signed [15:0] max_reg;

    logic shift;

    div_t  r_chain [0:DivCellsRatio];
    norm_t n_chain [0:NormCells];
    sq_t   s_chain [0:SqCells];
    div_t  t_chain [0:DivCellsTerm];
    div_t  k_chain [0:DivCellsKelvin];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg  <= 12'd3300;
            fixed_reg   <= 20'd10000;
            nominal_reg <= 20'd100000;
            beta_reg    <= 14'd4190;
            min_reg     <= -16'sd4000;
            max_reg     <= 16'sd15000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SUPPLY:  supply_reg  <= cfg_data[11:0];
                REG_FIXED:   fixed_reg   <= cfg_data;
                REG_NOMINAL: nominal_reg <= cfg_data;
                REG_BETA:    beta_reg    <= cfg_data[13:0];
                REG_MIN:     min_reg     <= $signed(cfg_data[15:0]);
                REG_MAX:     max_reg     <= $signed(cfg_data[15:0]);
                default:     ;
            endcase
        end
    end

    // the chain moves unless the output holds a result and the last cell is full
    logic out_valid_reg;
    assign shift    = !out_valid_reg || out_ready || !k_chain[DivCellsKelvin].vld;
    assign in_ready = shift;

    // stage 0: range checks and the two products of the ratio
    logic        s0_ok;
    logic [31:0] s0_fm;
    logic [11:0] s0_diff;
    logic [31:0] s0_dd;
    div_t        s0_next;
    div_t        s0_reg;
    logic        s0_vld_reg;

    always_comb
    begin
        s0_ok = in_item.read_ok && (in_item.tap_millivolts != 12'd0)
                && (in_item.tap_millivolts < supply_reg)
                && (nominal_reg != 20'd0) && (beta_reg != 14'd0);
        s0_fm   = fixed_reg * in_item.tap_millivolts;
        s0_diff = supply_reg - in_item.tap_millivolts;
        s0_dd   = s0_diff * nominal_reg;
        s0_next     = '0;
        s0_next.bad = !s0_ok;
        s0_next.num = {s0_fm, 16'd0};
        s0_next.den = {16'd0, s0_dd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (shift)
        begin
            s0_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            s0_reg <= s0_next;
        end
    end

    always_comb
    begin
        r_chain[0]     = s0_reg;
        r_chain[0].vld = s0_vld_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DivCellsRatio; gi++)
        begin : g_ratio
            ntc_div_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (shift),
                .d     (r_chain[gi]),
                .q     (r_chain[gi+1])
            );
        end
    endgenerate

    // ratio saturation and zero check
    logic [47:0] rat_q;
    logic [31:0] rat_x;
    norm_t       rat_next;
    norm_t       rat_reg;
    logic        rat_vld_reg;

    always_comb
    begin
        rat_q = r_chain[DivCellsRatio].quo;
        rat_x = (rat_q[47:32] != 16'd0) ? 32'hFFFF_FFFF : rat_q[31:0];
        rat_next.vld = 1'b0;
        rat_next.bad = r_chain[DivCellsRatio].bad || (rat_x == 32'd0);
        rat_next.x   = rat_x;
        rat_next.p   = 5'd31;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rat_vld_reg <= 1'b0;
        end
        else if (shift)
        begin
            rat_vld_reg <= r_chain[DivCellsRatio].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            rat_reg <= rat_next;
        end
    end

    always_comb
    begin
        n_chain[0]     = rat_reg;
        n_chain[0].vld = rat_vld_reg;
    end

    generate
        for (gi = 0; gi < NormCells; gi++)
        begin : g_norm
            ntc_norm_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (shift),
                .d     (n_chain[gi]),
                .q     (n_chain[gi+1])
            );
        end
    endgenerate

    // mantissa in q1.30 from the normalised word
    always_comb
    begin
        s_chain[0].vld  = n_chain[NormCells].vld;
        s_chain[0].bad  = n_chain[NormCells].bad;
        s_chain[0].m    = n_chain[NormCells].x[31:1];
        s_chain[0].frac = 30'd0;
        s_chain[0].p    = n_chain[NormCells].p;
    end

    generate
        for (gi = 0; gi < SqCells; gi++)
        begin : g_sq
            ntc_sq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (shift),
                .d     (s_chain[gi]),
                .q     (s_chain[gi+1])
            );
        end
    endgenerate

    // magnitude of the signed log2
    logic signed [5:0]  mag_e;
    logic signed [35:0] mag_l2;
    logic [35:0]        mag_l2_neg;
    logic [34:0]        mag_next;
    logic [34:0]        mag_reg;
    logic               mag_neg_reg;
    logic               mag_bad_reg;
    logic               mag_vld_reg;

    always_comb
    begin
        mag_e      = $signed({1'b0, s_chain[SqCells].p}) - 6'sd16;
        mag_l2     = {mag_e, s_chain[SqCells].frac};
        mag_l2_neg = -mag_l2;
        mag_next   = mag_e[5] ? mag_l2_neg[34:0] : mag_l2[34:0];
    end

    // ln = log2 * ln2, split in two partial products
    logic [47:0] ln_hi_reg;
    logic [46:0] ln_lo_reg;
    logic        ln_neg_reg;
    logic        ln_bad_reg;
    logic        ln_vld_reg;
    logic [64:0] ln_sum;
    logic [34:0] ln_mag;
    div_t        ln_next;
    div_t        ln_reg;
    logic        ln2_vld_reg;

    always_comb
    begin
        ln_sum  = {ln_hi_reg, 17'd0} + {18'd0, ln_lo_reg};
        ln_mag  = ln_sum[64:30];
        ln_next     = '0;
        ln_next.bad = ln_bad_reg;
        ln_next.neg = ln_neg_reg;
        ln_next.num = {ln_mag, 13'd0};
        ln_next.den = {34'd0, beta_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_vld_reg <= 1'b0;
            ln_vld_reg  <= 1'b0;
            ln2_vld_reg <= 1'b0;
        end
        else if (shift)
        begin
            mag_vld_reg <= s_chain[SqCells].vld;
            ln_vld_reg  <= mag_vld_reg;
            ln2_vld_reg <= ln_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            mag_reg     <= mag_next;
            mag_neg_reg <= mag_e[5];
            mag_bad_reg <= s_chain[SqCells].bad;
            ln_hi_reg   <= mag_reg[34:17] * Ln2Q30;
            ln_lo_reg   <= mag_reg[16:0] * Ln2Q30;
            ln_neg_reg  <= mag_neg_reg;
            ln_bad_reg  <= mag_bad_reg;
            ln_reg      <= ln_next;
        end
    end

    always_comb
    begin
        t_chain[0]     = ln_reg;
        t_chain[0].vld = ln2_vld_reg;
    end

    generate
        for (gi = 0; gi < DivCellsTerm; gi++)
        begin : g_term
            ntc_div_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (shift),
                .d     (t_chain[gi]),
                .q     (t_chain[gi+1])
            );
        end
    endgenerate

    // reciprocal temperature, then the rounded dividend of the kelvin divide
    logic signed [46:0] rec_inv;
    logic signed [46:0] rec_term;
    logic signed [46:0] rec_next;
    logic signed [46:0] rec_reg;
    logic               rec_bad_reg;
    logic               rec_vld_reg;
    div_t               kd_next;
    div_t               kd_reg;
    logic               kd_vld_reg;

    always_comb
    begin
        rec_inv  = $signed({15'd0, InvT25Q40});
        rec_term = $signed({2'd0, t_chain[DivCellsTerm].quo[44:0]});
        rec_next = t_chain[DivCellsTerm].neg ? (rec_inv - rec_term) : (rec_inv + rec_term);
        kd_next     = '0;
        kd_next.bad = rec_bad_reg;
        kd_next.num = CentiKNum + {3'd0, rec_reg[45:1]};
        kd_next.den = {2'd0, rec_reg[45:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_vld_reg <= 1'b0;
            kd_vld_reg  <= 1'b0;
        end
        else if (shift)
        begin
            rec_vld_reg <= t_chain[DivCellsTerm].vld;
            kd_vld_reg  <= rec_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            rec_reg     <= rec_next;
            rec_bad_reg <= t_chain[DivCellsTerm].bad || rec_next[46]
                           || (rec_next == 47'sd0);
            kd_reg      <= kd_next;
        end
    end

    always_comb
    begin
        k_chain[0]     = kd_reg;
        k_chain[0].vld = kd_vld_reg;
    end

    generate
        for (gi = 0; gi < DivCellsKelvin; gi++)
        begin : g_kelvin
            ntc_div_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (shift),
                .d     (k_chain[gi]),
                .q     (k_chain[gi+1])
            );
        end
    endgenerate

    // celsius conversion and window check into the output register
    logic signed [48:0] fin_tc;
    logic signed [48:0] fin_min;
    logic signed [48:0] fin_max;
    logic               fin_ok;
    out_item_t          out_item_next;
    out_item_t          out_item_reg;
    logic               out_valid_next;
    logic               out_load;

    always_comb
    begin
        fin_tc  = $signed({1'b0, k_chain[DivCellsKelvin].quo}) - ZeroCCentiK;
        fin_min = 49'(min_reg);
        fin_max = 49'(max_reg);
        fin_ok  = !k_chain[DivCellsKelvin].bad && (fin_tc >= fin_min) && (fin_tc <= fin_max);
        out_item_next.temp_centi_celsius = fin_ok ? fin_tc[15:0] : 16'sd0;
        out_item_next.temp_valid         = fin_ok;
        out_load       = shift && k_chain[DivCellsKelvin].vld;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `NTC_ASSERT_HOLDS(a_invalid_zero, out_valid && !out_item.temp_valid, out_item.temp_centi_celsius == 16'sd0, "invalid result carries a nonzero temperature")
    `NTC_ASSERT_HOLDS(a_in_window, out_valid && out_item.temp_valid, (out_item.temp_centi_celsius >= min_reg) && (out_item.temp_centi_celsius <= max_reg), "valid result outside the window")
    `NTC_ASSERT_HOLDS(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")
    `NTC_ASSERT_NEXT(a_failed_read, in_valid && in_ready && !in_item.read_ok, s0_reg.bad, "failed read not flagged")
endmodule
`default_nettype wire

// ===== sim/tb_ntc_beta_temperature_converter_unit.sv =====
// testbench of the ntc beta temperature converter: directed and random readings checked
`timescale 1ns / 1ps
`default_nettype none
module tb_ntc_beta_temperature_converter_unit;
    import ntc_pkg::*;

    localparam int LATENCY     = 210;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ZERO_C      = 27315;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    in_item_t            in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    // shadow copy of the converter registers
    logic [11:0]        supply_mv;
    logic [19:0]        fixed_ohms;
    logic [19:0]        nominal_ohms;
    logic [13:0]        beta_k;
    logic signed [15:0] min_cc;
    logic signed [15:0] max_cc;

    out_item_t pending_temps[$];
    int        error_count = 0;
    int        readings_sent = 0;
    int        temps_checked = 0;
    int        valid_temps = 0;
    int        cycle_count = 0;
    bit        sender_idles = 1'b1;
    bit        receiver_stalls = 1'b1;

    ntc_beta_temperature_converter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time, pending_temps.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= !receiver_stalls || ($urandom_range(99) >= 19);
    end

    // beta equation in fixed point, from the tap voltage to hundredths of a degree
    function automatic out_item_t beta_temperature(in_item_t rd);
        out_item_t   res;
        logic [63:0] den, ratio, m, frac, mag, lnmag, term, ck;
        int          p;
        longint      l2, rec, tc;
        res = '0;
        if (!rd.read_ok || rd.tap_millivolts == 0 || rd.tap_millivolts >= supply_mv)
            return res;
        if (nominal_ohms == 0 || beta_k == 0)
            return res;
        den   = 64'(supply_mv - rd.tap_millivolts) * 64'(nominal_ohms);
        ratio = ((64'(fixed_ohms) * 64'(rd.tap_millivolts)) << 16) / den;
        if (ratio > 64'hFFFF_FFFF)
            ratio = 64'hFFFF_FFFF;
        if (ratio == 0)
            return res;
        p = 31;
        while (p > 0 && !ratio[p])
            p--;
        m = (p >= 30) ? (ratio >> (p - 30)) : (ratio << (30 - p));
        frac = '0;
        // log2 fraction by repeated squaring of the normalised mantissa
        for (int i = 1; i <= 30; i++)
        begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac[30 - i] = 1'b1;
            end
        end
        l2    = longint'(p - 16) * (longint'(1) << 30) + longint'(frac);
        mag   = (l2 < 0) ? 64'(-l2) : 64'(l2);
        lnmag = (mag * 64'(Ln2Q30)) >> 30;
        term  = (lnmag << 10) / 64'(beta_k);
        rec   = (l2 < 0) ? longint'(InvT25Q40) - longint'(term)
                         : longint'(InvT25Q40) + longint'(term);
        if (rec <= 0)
            return res;
        ck = (64'(CentiKNum) + 64'(rec) / 2) / 64'(rec);
        tc = longint'(ck) - ZERO_C;
        if (tc < longint'(min_cc) || tc > longint'(max_cc))
            return res;
        res.temp_centi_celsius = tc[15:0];
        res.temp_valid         = 1'b1;
        return res;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_temps.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual temp %0d valid %0b",
                         $time, out_item.temp_centi_celsius, out_item.temp_valid);
                error_count++;
            end
            else
            begin
                want = pending_temps.pop_front();
                temps_checked++;
                if (want.temp_valid)
                    valid_temps++;
                if (want.temp_centi_celsius !== out_item.temp_centi_celsius)
                begin
                    $display("%0t temp mismatch: expected %0d, actual %0d", $time,
                             want.temp_centi_celsius, out_item.temp_centi_celsius);
                    error_count++;
                end
                if (want.temp_valid !== out_item.temp_valid)
                begin
                    $display("%0t valid mismatch: expected %0b, actual %0b", $time,
                             want.temp_valid, out_item.temp_valid);
                    error_count++;
                end
            end
        end
    end

    task automatic send_reading(input logic ok, input logic [11:0] mv);
        in_item_t rd;
        rd.read_ok        = ok;
        rd.tap_millivolts = mv;
        @(negedge clk);
        // each cycle idles with the same odds, so idle runs stay short
        if (sender_idles)
        begin
            while ($urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= rd;
        do
            @(posedge clk);
        while (!in_ready);
        pending_temps.push_back(beta_temperature(rd));
        readings_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SUPPLY:  supply_mv    = val[11:0];
            REG_FIXED:   fixed_ohms   = val[19:0];
            REG_NOMINAL: nominal_ohms = val[19:0];
            REG_BETA:    beta_k       = val[13:0];
            REG_MIN:     min_cc       = val[15:0];
            REG_MAX:     max_cc       = val[15:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input int sup, input int fx, input int nom, input int bk,
                           input int lo, input int hi);
        write_reg(REG_SUPPLY, 20'(sup));
        write_reg(REG_FIXED, 20'(fx));
        write_reg(REG_NOMINAL, 20'(nom));
        write_reg(REG_BETA, 20'(bk));
        write_reg(REG_MIN, 20'(lo));
        write_reg(REG_MAX, 20'(hi));
    endtask

    task automatic test_reset_values;
        send_reading(1'b0, 12'd1650);
        send_reading(1'b1, 12'd0);
        send_reading(1'b1, 12'd1);
        send_reading(1'b1, 12'd1650);
        send_reading(1'b1, 12'd3299);
        send_reading(1'b1, 12'd3300);
        send_reading(1'b1, 12'd4095);
        send_reading(1'b0, 12'd4095);
        send_reading(1'b1, 12'd300);
        drain();
    endtask

    task automatic test_odd_registers;
        // zero fixed resistor gives a zero ratio
        write_reg(REG_FIXED, 20'd0);
        send_reading(1'b1, 12'd1000);
        drain();
        write_reg(REG_FIXED, 20'd10000);
        write_reg(REG_NOMINAL, 20'd0);
        send_reading(1'b1, 12'd1000);
        drain();
        write_reg(REG_NOMINAL, 20'd10000);
        write_reg(REG_BETA, 20'd0);
        send_reading(1'b1, 12'd1000);
        drain();
        // min above max, and writes to unused indexes
        write_reg(REG_BETA, 20'd3950);
        write_reg(REG_MIN, 20'd2000);
        write_reg(REG_MAX, 20'd1000);
        write_reg(3'd6, 20'hFFFFF);
        write_reg(3'd7, 20'hFFFFF);
        send_reading(1'b1, 12'd1650);
        drain();
        // zero supply, then huge ratio at the widest window
        set_all(0, 10000, 10000, 3950, -5500, 25000);
        send_reading(1'b1, 12'd1);
        drain();
        set_all(4095, 20'hFFFFF, 1, 16383, 16'h8000, 16'h7FFF);
        send_reading(1'b1, 12'd4094);
        send_reading(1'b1, 12'd1);
        send_reading(1'b1, 12'd2048);
        drain();
        set_all(1, 1, 1000000, 1000, 25000, 25000);
        send_reading(1'b1, 12'd0);
        send_reading(1'b1, 12'd1);
        drain();
    endtask

    task automatic random_phase(input int n_readings, input bit realistic);
        int mv;
        for (int k = 0; k < n_readings; k++)
        begin
            if (realistic && $urandom_range(99) < 85)
                mv = (supply_mv > 1) ? $urandom_range(int'(supply_mv) - 1, 1) : 0;
            else
                mv = $urandom_range(4095);
            send_reading($urandom_range(99) < 90, 12'(mv));
            if (k == n_readings / 2 && $urandom_range(3) == 0)
                drain();
        end
        drain();
    endtask

    task automatic test_random_readings;
        int lo, hi;
        // defaults first, with neither side idling
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        set_all(3300, 10000, 100000, 4190, -4000, 15000);
        random_phase(120, 1'b1);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        set_all(4095, 1000000, 1000000, 10000, -5500, 25000);
        random_phase(60, 1'b1);
        set_all(1000, 1, 1, 1000, -5500, 25000);
        random_phase(40, 1'b1);
        for (int ph = 0; ph < 8; ph++)
        begin
            lo = $urandom_range(30500) - 5500;
            hi = $urandom_range(30500) - 5500;
            if (ph % 2 == 0)
            begin
                lo = -5500;
                hi = 25000;
            end
            set_all($urandom_range(4095, 500), $urandom_range(200000, 1000),
                    $urandom_range(200000, 1000), $urandom_range(10000, 1000), lo, hi);
            random_phase(50, 1'b1);
        end
        set_all($urandom_range(4095), $urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF),
                $urandom_range(16383), $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
        random_phase(30, 1'b0);
    endtask

    initial
    begin
        supply_mv    = 12'd3300;
        fixed_ohms   = 20'd10000;
        nominal_ohms = 20'd100000;
        beta_k       = 14'd4190;
        min_cc       = -16'sd4000;
        max_cc       = 16'sd15000;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_odd_registers();
        test_random_readings();
        $display("covered %0d readings, %0d results checked (%0d in window),",
                 readings_sent, temps_checked, valid_temps);
        $display("register extremes, odd settings and random configurations with idling");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
